// File: src/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg: shared types and codes of the interval partition table
// Operation codes, status codes, controller states and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package ipt_pkg;

    typedef enum logic [3:0] {
        FN_FIND      = 4'd0,
        FN_GET       = 4'd1,
        FN_FIND_BND  = 4'd2,
        FN_MOVE      = 4'd3,
        FN_INSERT    = 4'd4,
        FN_REMOVE    = 4'd5,
        FN_SPLIT     = 4'd6,
        FN_MERGE_L   = 4'd7,
        FN_MERGE_R   = 4'd8,
        FN_REINIT    = 4'd9
    } t_func;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_BAD_ARG = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int FUNC_W = 4;
    localparam int SEL_W  = 4;
    localparam int STAT_W = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input word
        logic execute;   // apply the latched operation
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic dummy_ok;  // operation latched and ready to execute
    } t_sts;

endpackage
`default_nettype wire

// File: src/interval_partition_table_unit.sv
// ----------------------------------------------------------------------------
// interval_partition_table_unit: sorted table of group end positions
// Splits a frame timeline into up to MAX_GROUPS groups and edits it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per operation, tdata = {group_sel, position, func}
//   from the high bit down. Master stream: one result word per operation,
//   tdata = {group_removed, range_end, range_begin, group_index, status}.
//   APB port: register 0 (address 0) is initial_length; reads return it.
// Sequence: a word is captured at the accepting edge, the table is updated and
//   the result registered at the next edge by the parallel compare and shift
//   logic over all entries; m_tvalid rises with that registered result and
//   holds until the master side takes it.
// Flow: no new word is taken while an operation is under way; a new word is
//   accepted while idle or in the cycle the previous result leaves.
// Reset: the table holds one group ending at 1, initial_length reads 1.
// Stall: while m_tready is low, the result holds on the
//   master port and no new word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_partition_table_unit #(
    parameter int MAX_GROUPS = 16,
    parameter int FRAME_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // func[3:0], position[19:4], group_sel[23:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[1:0], group_index[5:2],
                                        // range_begin[21:6], range_end[37:22],
                                        // group_removed[38], zero fill
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    ipt_pkg::t_cmd w_cmd;
    ipt_pkg::t_sts w_sts;
    logic [1:0]  w_status;
    logic [3:0]  w_gi;
    logic [15:0] w_rb, w_re, w_len;
    logic        w_rem;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, w_len} : 32'd0;

    ipt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid)
    );

    ipt_datapath #(
        .MAX_GROUPS (MAX_GROUPS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (s_tdata[3:0]),
        .i_position      (s_tdata[19:4]),
        .i_group_sel     (s_tdata[23:20]),
        .i_cfg_we        (psel && penable && pwrite && paddr == 2'd0),
        .i_cfg_len       (pwdata[15:0]),
        .o_cfg_len       (w_len),
        .o_status        (w_status),
        .o_group_index   (w_gi),
        .o_range_begin   (w_rb),
        .o_range_end     (w_re),
        .o_group_removed (w_rem)
    );

    assign m_tdata = {1'b0, w_rem, w_re, w_rb, w_gi, w_status};
endmodule
`default_nettype wire

// File: src/ipt_ctrl.sv
// ----------------------------------------------------------------------------
// ipt_ctrl: sequencer of the interval partition table
// Captures one word, runs the execute step, then holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire ipt_pkg::t_sts i_sts,
    output ipt_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    ipt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ipt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ipt_pkg::S_EXEC;
                end
            end
            ipt_pkg::S_EXEC: begin
                if (i_sts.dummy_ok) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ipt_pkg::S_OUT;
                end
            end
            ipt_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                // a taken result frees the input side in the same cycle
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ipt_pkg::S_EXEC;
                    end else begin
                        n_state = ipt_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = ipt_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: src/ipt_datapath.sv
// ----------------------------------------------------------------------------
// ipt_datapath: boundary registers and the parallel compare and shift logic
// Holds the end table and count, evaluates one operation per execute command.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_datapath #(
    parameter int MAX_GROUPS = 16,
    parameter int FRAME_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ipt_pkg::t_cmd                i_cmd,
    output ipt_pkg::t_sts                     o_sts,
    input  wire logic [ipt_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [15:0]                  i_position,
    input  wire logic [ipt_pkg::SEL_W-1:0]    i_group_sel,
    input  wire logic                         i_cfg_we,
    input  wire logic [15:0]                  i_cfg_len,
    output logic [15:0]                       o_cfg_len,
    output logic [ipt_pkg::STAT_W-1:0]        o_status,
    output logic [ipt_pkg::SEL_W-1:0]         o_group_index,
    output logic [15:0]                       o_range_begin,
    output logic [15:0]                       o_range_end,
    output logic                              o_group_removed
);
    localparam int IW = $clog2(MAX_GROUPS);
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int PW = (FRAME_BITS > 16) ? FRAME_BITS : 16;
    localparam logic [FRAME_BITS-1:0] FMAX = {FRAME_BITS{1'b1}};
    localparam logic [FRAME_BITS-1:0] FONE = FRAME_BITS'(1);

    typedef logic [FRAME_BITS-1:0] t_frame;

    t_frame                     r_ends [MAX_GROUPS];
    t_frame                     n_ends [MAX_GROUPS];
    logic [CW-1:0]              r_count, n_count;
    logic [15:0]                r_init_len;
    logic [ipt_pkg::FUNC_W-1:0] r_func;
    logic [PW-1:0]              r_pos;
    logic [ipt_pkg::SEL_W-1:0]  r_sel;
    logic                       r_loaded;
    logic [ipt_pkg::STAT_W-1:0] r_status, n_status;
    logic [ipt_pkg::SEL_W-1:0]  r_gi, n_gi;
    t_frame                     r_rb, n_rb, r_re, n_re;
    logic                       r_rem, n_rem;

    // per-entry compares, used by every locate-style operation
    logic [MAX_GROUPS-1:0] w_live, w_past, w_eq;
    logic [IW-1:0]         w_loc, w_eqi;
    logic                  w_loc_ok, w_eq_ok, w_pos_hi;
    t_frame                w_pos, w_last, w_init;

    assign w_pos = t_frame'(r_pos);

    function automatic logic [IW-1:0] prio(input logic [MAX_GROUPS-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int j = MAX_GROUPS - 1; j >= 0; j--) begin
            if (v[j]) idx = IW'(j);
        end
        return idx;
    endfunction

    always_comb begin
        for (int j = 0; j < MAX_GROUPS; j++) begin
            w_live[j] = (CW'(j) < r_count);
            w_past[j] = w_live[j] && (w_pos < r_ends[j]);
            w_eq[j]   = w_live[j] && (w_pos == r_ends[j]);
        end
        // position above the frame range lies past every end
        w_pos_hi = (r_pos > PW'(FMAX));
        w_loc    = prio(w_past);
        w_loc_ok = |w_past && !w_pos_hi;
        w_eqi    = prio(w_eq);
        w_eq_ok  = |w_eq && !w_pos_hi;
        w_last   = (r_count == '0) ? '0 : r_ends[IW'(r_count - CW'(1))];
        if (r_init_len == 16'd0) begin
            w_init = FONE;
        end else if (FRAME_BITS < 16 && {16'd0, r_init_len} > 32'(FMAX)) begin
            w_init = FMAX;
        end else begin
            w_init = t_frame'(r_init_len);
        end
    end

    function automatic t_frame beg(input t_frame e [MAX_GROUPS], input logic [IW-1:0] i);
        return (i == '0) ? '0 : e[i - IW'(1)];
    endfunction

    always_comb begin
        t_frame lo, hi, ev;
        logic [IW-1:0] s;
        logic sel_ok;
        for (int j = 0; j < MAX_GROUPS; j++) n_ends[j] = r_ends[j];
        n_count  = r_count;
        n_status = ipt_pkg::ST_BAD_ARG;
        n_gi     = '0;
        n_rb     = '0;
        n_re     = '0;
        n_rem    = 1'b0;
        s        = IW'(r_sel);
        sel_ok   = ({28'd0, r_sel} < 32'(r_count));
        lo = '0; hi = '0; ev = '0;
        // a large position beyond the frame range never matches
        case (r_func)
            ipt_pkg::FN_FIND: begin
                if (w_loc_ok) begin
                    n_status = ipt_pkg::ST_DONE;
                    n_gi = ipt_pkg::SEL_W'(w_loc);
                    n_rb = beg(r_ends, w_loc);
                    n_re = r_ends[w_loc];
                end
            end
            ipt_pkg::FN_GET: begin
                if (sel_ok) begin
                    n_status = ipt_pkg::ST_DONE;
                    n_gi = r_sel;
                    n_rb = beg(r_ends, s);
                    n_re = r_ends[s];
                end
            end
            ipt_pkg::FN_FIND_BND: begin
                n_status = ipt_pkg::ST_REFUSED;
                if (r_count != '0 && w_pos != '0 && w_pos < w_last && w_eq_ok) begin
                    n_status = ipt_pkg::ST_DONE;
                    n_gi = ipt_pkg::SEL_W'(w_eqi);
                    n_rb = beg(r_ends, w_eqi);
                    n_re = w_pos;
                end
            end
            ipt_pkg::FN_MOVE: begin
                if ({28'd0, r_sel} + 32'd1 < 32'(r_count)) begin
                    lo = (s == '0) ? FONE : r_ends[s - IW'(1)] + FONE;
                    hi = r_ends[s + IW'(1)] - FONE;
                    ev = w_pos_hi ? FMAX : w_pos;
                    if (ev < lo) ev = lo;
                    if (ev > hi) ev = hi;
                    n_status  = (r_ends[s] != ev) ? ipt_pkg::ST_DONE : ipt_pkg::ST_REFUSED;
                    n_ends[s] = ev;
                    n_gi = r_sel;
                    n_rb = beg(r_ends, s);
                    n_re = ev;
                end
            end
            ipt_pkg::FN_INSERT: begin
                if (w_loc_ok) begin
                    if (w_last >= FMAX) begin
                        n_status = ipt_pkg::ST_FULL;
                    end else begin
                        for (int j = 0; j < MAX_GROUPS; j++) begin
                            if (w_live[j] && IW'(j) >= w_loc) n_ends[j] = r_ends[j] + FONE;
                        end
                        n_status = ipt_pkg::ST_DONE;
                        n_gi = ipt_pkg::SEL_W'(w_loc);
                        n_rb = beg(r_ends, w_loc);
                        n_re = r_ends[w_loc] + FONE;
                    end
                end
            end
            ipt_pkg::FN_REMOVE: begin
                if (w_loc_ok) begin
                    lo = beg(r_ends, w_loc);
                    n_status = ipt_pkg::ST_DONE;
                    n_gi = ipt_pkg::SEL_W'(w_loc);
                    n_rb = lo;
                    if (r_ends[w_loc] - FONE == lo) begin
                        // group empties: close the gap and shift the tail down
                        n_rem = 1'b1;
                        n_re  = lo;
                        for (int j = 0; j < MAX_GROUPS - 1; j++) begin
                            if (IW'(j) >= w_loc && CW'(j + 1) < r_count)
                                n_ends[j] = r_ends[j + 1] - FONE;
                        end
                        n_count = r_count - CW'(1);
                    end else begin
                        n_re = r_ends[w_loc] - FONE;
                        for (int j = 0; j < MAX_GROUPS; j++) begin
                            if (w_live[j] && IW'(j) >= w_loc) n_ends[j] = r_ends[j] - FONE;
                        end
                    end
                end
            end
            ipt_pkg::FN_SPLIT: begin
                if (w_loc_ok) begin
                    if (w_pos == beg(r_ends, w_loc)) begin
                        n_status = ipt_pkg::ST_REFUSED;
                    end else if (32'(r_count) >= MAX_GROUPS) begin
                        n_status = ipt_pkg::ST_FULL;
                    end else begin
                        for (int j = 1; j < MAX_GROUPS; j++) begin
                            if (IW'(j) > w_loc && CW'(j) <= r_count) n_ends[j] = r_ends[j - 1];
                        end
                        n_ends[w_loc] = w_pos;
                        n_count  = r_count + CW'(1);
                        n_status = ipt_pkg::ST_DONE;
                        n_gi = ipt_pkg::SEL_W'(w_loc);
                        n_rb = beg(r_ends, w_loc);
                        n_re = w_pos;
                    end
                end
            end
            ipt_pkg::FN_MERGE_L, ipt_pkg::FN_MERGE_R: begin
                if (sel_ok) begin
                    if (r_func == ipt_pkg::FN_MERGE_L && s == '0) begin
                        n_status = ipt_pkg::ST_REFUSED;
                    end else if (r_func == ipt_pkg::FN_MERGE_R
                                 && {28'd0, r_sel} + 32'd1 == 32'(r_count)) begin
                        n_status = ipt_pkg::ST_REFUSED;
                    end else begin
                        // the surviving slot is k; entry k takes entry k+1's end
                        lo = '0;
                        if (r_func == ipt_pkg::FN_MERGE_L) s = s - IW'(1);
                        for (int j = 0; j < MAX_GROUPS - 1; j++) begin
                            if (IW'(j) >= s && CW'(j + 1) < r_count) n_ends[j] = r_ends[j + 1];
                        end
                        n_count  = r_count - CW'(1);
                        n_status = ipt_pkg::ST_DONE;
                        n_gi = ipt_pkg::SEL_W'(s);
                        n_rb = beg(r_ends, s);
                        n_re = r_ends[s + IW'(1)];
                    end
                end
            end
            ipt_pkg::FN_REINIT: begin
                n_ends[0] = w_init;
                n_count   = CW'(1);
                n_status  = ipt_pkg::ST_DONE;
                n_re      = w_init;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(1);
            r_init_len <= 16'd1;
            r_loaded   <= 1'b0;
            r_ends[0]  <= FONE;
        end else begin
            if (i_cfg_we) r_init_len <= i_cfg_len;
            if (i_cmd.capture) begin
                r_loaded <= 1'b1;
            end else if (i_cmd.execute) begin
                r_loaded <= 1'b0;
            end
            if (i_cmd.execute) begin
                r_count <= n_count;
                for (int j = 0; j < MAX_GROUPS; j++) r_ends[j] <= n_ends[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_pos  <= PW'(i_position);
            r_sel  <= i_group_sel;
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_gi     <= n_gi;
            r_rb     <= n_rb;
            r_re     <= n_re;
            r_rem    <= n_rem;
        end
    end

    assign o_sts.dummy_ok  = r_loaded;
    assign o_cfg_len       = r_init_len;
    assign o_status        = r_status;
    assign o_group_index   = r_gi;
    assign o_range_begin   = 16'(r_rb);
    assign o_range_end     = 16'(r_re);
    assign o_group_removed = r_rem;
endmodule
`default_nettype wire

// File: src/ipt_checker.sv
// ----------------------------------------------------------------------------
// ipt_checker: port-level checks of the interval partition table
// Watches the streams and the APB port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        pready
);
    // m_tvalid stays low while an accepted word executes, then rises with its result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !m_tvalid ##1 m_tvalid) else $error("late result");
    // no word accepted while an untaken result is waiting
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready) else $error("overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("drop");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind interval_partition_table_unit ipt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire

// File: test/interval_partition_table_unit_chk.sv
// ----------------------------------------------------------------------------
// interval_partition_table_unit_chk: result checker for the partition table
// Watches the slave and master streams and the APB port, keeps its own copy
// of the group end table, predicts one result word per operation word and
// compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_partition_table_unit_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic        removed;
        logic [15:0] rend;
        logic [15:0] rbegin;
        logic [3:0]  gidx;
        logic [1:0]  status;
    } t_result;

    logic [15:0] init_len;
    logic [15:0] ends [16];
    int          count;
    t_result     result_q [$];

    assign o_pending = result_q.size();

    function automatic logic [15:0] begin_at(int i);
        return (i == 0) ? 16'd0 : ends[i-1];
    endfunction

    function automatic int holder_of(logic [15:0] pos);
        for (int i = 0; i < count; i++)
            if (pos < ends[i]) return i;
        return count;
    endfunction

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < count; k++) ends[k] = ends[k+1];
        count--;
    endfunction

    function automatic void load_single();
        logic [15:0] len;
        len = (init_len == 16'd0) ? 16'd1 : init_len;
        for (int k = 0; k < 16; k++) ends[k] = '0;
        ends[0] = len;
        count = 1;
    endfunction

    function automatic t_result apply_op(logic [3:0] fn, logic [15:0] pos, logic [3:0] sel);
        t_result r;
        int i;
        int k;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] e;
        logic [15:0] prev;
        r = '0;
        r.status = ipt_pkg::ST_BAD_ARG;
        case (fn)
            ipt_pkg::FN_FIND: begin
                i = holder_of(pos);
                if (i < count) begin
                    r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                    r.rbegin = begin_at(i); r.rend = ends[i];
                end
            end
            ipt_pkg::FN_GET: begin
                if (sel < count) begin
                    r.status = ipt_pkg::ST_DONE; r.gidx = sel;
                    r.rbegin = begin_at(sel); r.rend = ends[sel];
                end
            end
            ipt_pkg::FN_FIND_BND: begin
                r.status = ipt_pkg::ST_REFUSED;
                if (count > 0 && pos > 0 && pos < ends[count-1]) begin
                    for (i = 0; i < count; i++) begin
                        if (ends[i] == pos) begin
                            r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                            r.rbegin = begin_at(i); r.rend = pos;
                            break;
                        end
                    end
                end
            end
            ipt_pkg::FN_MOVE: begin
                if (count >= 2 && sel + 1 < count) begin
                    lo = (sel == 0) ? 16'd1 : ends[sel-1] + 16'd1;
                    hi = ends[sel+1] - 16'd1;
                    e = pos;
                    if (e < lo) e = lo;
                    if (e > hi) e = hi;
                    r.status = (ends[sel] != e) ? ipt_pkg::ST_DONE : ipt_pkg::ST_REFUSED;
                    ends[sel] = e;
                    r.gidx = sel; r.rbegin = begin_at(sel); r.rend = e;
                end
            end
            ipt_pkg::FN_INSERT: begin
                i = holder_of(pos);
                if (i < count) begin
                    if (ends[count-1] == 16'hFFFF) begin
                        r.status = ipt_pkg::ST_FULL;
                    end else begin
                        for (k = i; k < count; k++) ends[k]++;
                        r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                        r.rbegin = begin_at(i); r.rend = ends[i];
                    end
                end
            end
            ipt_pkg::FN_REMOVE: begin
                i = holder_of(pos);
                if (i < count) begin
                    prev = begin_at(i);
                    r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                    ends[i]--;
                    if (ends[i] == prev) begin
                        drop_entry(i);
                        r.removed = 1'b1; r.rbegin = prev; r.rend = prev;
                        k = i;
                    end else begin
                        r.rbegin = prev; r.rend = ends[i];
                        k = i + 1;
                    end
                    for (; k < count; k++) ends[k]--;
                end
            end
            ipt_pkg::FN_SPLIT: begin
                i = holder_of(pos);
                if (i < count) begin
                    if (pos == begin_at(i)) begin
                        r.status = ipt_pkg::ST_REFUSED;
                    end else if (count >= 16) begin
                        r.status = ipt_pkg::ST_FULL;
                    end else begin
                        for (k = count; k > i; k--) ends[k] = ends[k-1];
                        ends[i] = pos;
                        count++;
                        r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                        r.rbegin = begin_at(i); r.rend = pos;
                    end
                end
            end
            ipt_pkg::FN_MERGE_L: begin
                if (sel < count) begin
                    if (sel == 0) begin
                        r.status = ipt_pkg::ST_REFUSED;
                    end else begin
                        drop_entry(sel - 1);
                        i = sel - 1;
                        r.status = ipt_pkg::ST_DONE; r.gidx = 4'(i);
                        r.rbegin = begin_at(i); r.rend = ends[i];
                    end
                end
            end
            ipt_pkg::FN_MERGE_R: begin
                if (sel < count) begin
                    if (sel + 1 == count) begin
                        r.status = ipt_pkg::ST_REFUSED;
                    end else begin
                        ends[sel] = ends[sel+1];
                        drop_entry(sel + 1);
                        r.status = ipt_pkg::ST_DONE; r.gidx = sel;
                        r.rbegin = begin_at(sel); r.rend = ends[sel];
                    end
                end
            end
            ipt_pkg::FN_REINIT: begin
                load_single();
                r.status = ipt_pkg::ST_DONE; r.rend = ends[0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            init_len = 16'd1;
            load_single();
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                init_len = pwdata[15:0];
            // predict on every accepted operation word
            if (s_tvalid && s_tready)
                result_q.push_back(apply_op(s_tdata[3:0], s_tdata[19:4], s_tdata[23:20]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[38:0];
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.gidx !== want.gidx)
                        report_mismatch("group_index", got.gidx, want.gidx);
                    if (got.rbegin !== want.rbegin)
                        report_mismatch("range_begin", got.rbegin, want.rbegin);
                    if (got.rend !== want.rend)
                        report_mismatch("range_end", got.rend, want.rend);
                    if (got.removed !== want.removed)
                        report_mismatch("group_removed", got.removed, want.removed);
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: test/interval_partition_table_unit_tb.sv
// ----------------------------------------------------------------------------
// interval_partition_table_unit_tb: stimulus and verdict for the table unit
// Drives directed and random operation words with random gaps and result
// stalls, reprograms initial_length between phases over its extremes and
// leaves all checking to the checker module.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_partition_table_unit_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    // idle percentage of both sides; zero during the calm stretch
    int          idle_pct;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    interval_partition_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    interval_partition_table_unit_chk u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .o_errors (errors),
        .o_pending(pending)
    );

    // Stall the master side at random, except in the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Send one word: optional idle gap, then hold valid until accepted.
    // Valid stays high after acceptance; the next call or drain replaces it.
    task automatic send_word(ipt_pkg::t_func fn, logic [15:0] pos, logic [3:0] sel);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sel, pos, fn};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Unused codes go through the same path to test the bad-argument case.
    task automatic send_raw(logic [3:0] fn, logic [15:0] pos, logic [3:0] sel);
        send_word(ipt_pkg::t_func'(fn), pos, sel);
    endtask

    // Hold off until every expected result is back, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly pick positions inside the current timeline, sometimes anywhere.
    function automatic logic [15:0] pick_pos(int span);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(span));
    endfunction

    // Random phase: a random mix of operations, splits the most common to build up groups.
    task automatic random_phase(int n, int span);
        int r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 22)
                send_word(ipt_pkg::FN_SPLIT, pick_pos(span), 4'($urandom));
            else if (r < 32)
                send_word(ipt_pkg::FN_FIND, pick_pos(span), 4'($urandom));
            else if (r < 38)
                send_word(ipt_pkg::FN_GET, 16'($urandom), 4'($urandom));
            else if (r < 45)
                send_word(ipt_pkg::FN_FIND_BND, pick_pos(span), 4'($urandom));
            else if (r < 57)
                send_word(ipt_pkg::FN_MOVE, pick_pos(span), 4'($urandom));
            else if (r < 66)
                send_word(ipt_pkg::FN_INSERT, pick_pos(span), 4'($urandom));
            else if (r < 78)
                send_word(ipt_pkg::FN_REMOVE, pick_pos(span), 4'($urandom));
            else if (r < 85)
                send_word(ipt_pkg::FN_MERGE_L, 16'($urandom), 4'($urandom));
            else if (r < 92)
                send_word(ipt_pkg::FN_MERGE_R, 16'($urandom), 4'($urandom));
            else if (r < 96)
                send_word(ipt_pkg::FN_REINIT, 16'($urandom), 4'($urandom));
            else
                send_raw(4'($urandom_range(15, 10)), 16'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 36;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset table is one group of one frame.
        send_word(ipt_pkg::FN_FIND, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_FIND, 16'd1, 4'd0);
        send_word(ipt_pkg::FN_GET, 16'd0, 4'd15);
        send_word(ipt_pkg::FN_FIND_BND, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_SPLIT, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_MERGE_L, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_MERGE_R, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_MOVE, 16'hFFFF, 4'd0);
        send_word(ipt_pkg::FN_REMOVE, 16'd0, 4'd0);   // erases the only group
        send_word(ipt_pkg::FN_FIND, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_FIND_BND, 16'd5, 4'd0);
        send_raw(4'hF, 16'hFFFF, 4'hF);
        send_raw(4'd10, 16'd0, 4'd0);
        drain();

        // Largest table: frame overflow on insert, splits to a full table.
        apb_write(16'hFFFF);
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_INSERT, 16'd7, 4'd0);
        send_word(ipt_pkg::FN_SPLIT, 16'hFFFE, 4'd0);
        send_word(ipt_pkg::FN_FIND_BND, 16'hFFFE, 4'd0);
        send_word(ipt_pkg::FN_MOVE, 16'd0, 4'd0);
        send_word(ipt_pkg::FN_MOVE, 16'd1, 4'd0);
        for (int k = 1; k <= 15; k++)
            send_word(ipt_pkg::FN_SPLIT, 16'(k * 1000), 4'd0);
        send_word(ipt_pkg::FN_MERGE_R, 16'd0, 4'd15);
        send_word(ipt_pkg::FN_MERGE_L, 16'd0, 4'd15);
        drain();

        // Zero length is treated as one.
        apb_write(16'd0);
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        drain();

        apb_write(16'd64);
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        random_phase(300, 80);
        drain();

        // Calm stretch: no idling on either side.
        apb_write(16'd1);
        idle_pct = 0;
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        random_phase(150, 20);
        drain();

        idle_pct = 36;
        apb_write(16'd40000);
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        random_phase(150, 65535);
        drain();

        apb_write(16'd200);
        send_word(ipt_pkg::FN_REINIT, 16'd0, 4'd0);
        random_phase(300, 260);
        drain();

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// File: interval_partition_table_unit.f
src/ipt_pkg.sv
src/ipt_ctrl.sv
src/ipt_datapath.sv
src/interval_partition_table_unit.sv
src/ipt_checker.sv
test/interval_partition_table_unit_chk.sv
test/interval_partition_table_unit_tb.sv
